>>> hdl/phagc_pkg.sv
// Package for the peak-hold audio AGC: state codes, controller command and
// status structures and the fixed-point constants of the gain law.
// Depends on nothing; all other files but phagc_ram import it.
package phagc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int PEAK_W   = 23;
    localparam int GAIN_W   = 22;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int NUM_W    = 39;
    localparam int DIV_CNT_W = 6;

    localparam logic [GAIN_W-1:0]    GAIN_MAX   = 22'd3276800;
    localparam logic [GAIN_W-1:0]    GAIN_RESET = 22'd1638400;
    localparam logic [PEAK_W-1:0]    PEAK_MAX   = 23'd8388607;
    localparam logic [NUM_W-1:0]     TARGET_NUM = 39'd503316480000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 6'd38;
    // ceil(2^22 / 5): exact floor(x / 5) for x below 2^20.
    localparam logic [19:0]          RECIP5     = 20'd838861;
    localparam logic [14:0]          SAT_MAX    = 15'd32767;
    localparam logic [23:0]          HALF_LSB   = 24'h800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_SCAN,
        ST_DIV_INIT,
        ST_DIV,
        ST_LIMIT,
        ST_UPDATE,
        ST_SWAP
    } phagc_state_t;

    typedef struct packed {
        logic accept;
        logic mult;
        logic emit;
        logic hist_write;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic limit;
        logic update;
        logic swap;
    } phagc_cmd_t;

    typedef struct packed {
        logic end_of_frame;
        logic drain_valid;
        logic out_free;
        logic agc_en;
        logic scan_last;
        logic div_last;
    } phagc_status_t;

endpackage

>>> hdl/phagc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module phagc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/phagc_ctrl.sv
// Controller state machine of the peak-hold AGC: sequences sample handling
// and the frame-end gain update. Depends on phagc_pkg.
module phagc_ctrl
    import phagc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  phagc_status_t status,
    output phagc_cmd_t    cmd
);

    phagc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.drain_valid || status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.end_of_frame)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.agc_en)
                    begin
                        cmd.hist_write = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SWAP;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/phagc_dp.sv
// Datapath of the peak-hold AGC: frame buffers, peak tracking, history scan,
// divider, gain law and output register. Depends on phagc_pkg and phagc_ram.
module phagc_dp
    import phagc_pkg::*;
#(
    parameter int FRAME_LEN     = 160,
    parameter int HISTORY_DEPTH = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  phagc_cmd_t                 cmd,
    output phagc_status_t              status,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [OUT_W-1:0]    sample_out,
    output logic [GAIN_W-1:0]          applied_gain,
    output logic                       frame_end
);

    localparam int POS_W  = $clog2(FRAME_LEN);
    localparam int ADDR_W = POS_W + 1;
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_LEN - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    logic                     agc_en_reg;
    logic [POS_W-1:0]         pos_reg;
    logic                     bank_reg;
    logic                     end_reg;
    logic [PEAK_W-1:0]        peak_reg;
    logic [PEAK_W-1:0]        hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        scan_reg;
    logic [PEAK_W-1:0]        max_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [PEAK_W-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic [17:0]              lim_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [GAIN_W-1:0]        drain_gain_reg;
    logic                     drain_valid_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  sample_out_reg;
    logic [GAIN_W-1:0]        gain_out_reg;
    logic                     frame_end_reg;

    logic signed [SAMPLE_W-1:0] rd_sample;
    logic [SAMPLE_W-1:0]        in_mag;
    logic [PEAK_W-1:0]          in_peak;
    logic [SAMPLE_W-1:0]        rd_mag;

    // Ping-pong buffer: the bank being filled and the one being drained.
    phagc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 ** ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr ({bank_reg, pos_reg}),
        .wdata (sample_in),
        .raddr ({~bank_reg, pos_reg}),
        .rdata (rd_sample)
    );

    assign in_mag  = sample_in[SAMPLE_W-1] ? SAMPLE_W'(-sample_in) : SAMPLE_W'(sample_in);
    assign in_peak = (in_mag > {1'b0, PEAK_MAX}) ? PEAK_MAX : in_mag[PEAK_W-1:0];
    assign rd_mag  = rd_sample[SAMPLE_W-1] ? SAMPLE_W'(-rd_sample) : SAMPLE_W'(rd_sample);

    // Rounding half to even and saturation of the registered product.
    logic [GAIN_W-1:0] rnd_int;
    logic [23:0]       rnd_frac;
    logic              rnd_inc;
    logic [GAIN_W:0]   rnd_sum;
    logic [14:0]       rnd_sat;
    logic [OUT_W-1:0]  rnd_abs;
    logic [OUT_W-1:0]  rnd_out;

    always_comb
    begin
        rnd_int  = prod_reg[PROD_W-1:24];
        rnd_frac = prod_reg[23:0];
        rnd_inc  = (rnd_frac > HALF_LSB) || ((rnd_frac == HALF_LSB) && rnd_int[0]);
        rnd_sum  = {1'b0, rnd_int} + {{GAIN_W{1'b0}}, rnd_inc};
        rnd_sat  = (rnd_sum > {8'd0, SAT_MAX}) ? SAT_MAX : rnd_sum[14:0];
        rnd_abs  = {1'b0, rnd_sat};
        rnd_out  = neg_reg ? (~rnd_abs + 16'd1) : rnd_abs;
    end

    // One restoring division step.
    logic [PEAK_W:0]   div_sh;
    logic              div_ge;
    logic [PEAK_W:0]   div_diff;

    always_comb
    begin
        div_sh   = {rem_reg, num_reg[NUM_W-1]};
        div_ge   = div_sh >= {1'b0, max_reg};
        div_diff = div_sh - {1'b0, max_reg};
    end

    // Gain law: a lower target is taken at once, a higher one approached.
    logic [39:0]       lim_prod;
    logic [GAIN_W-1:0] tgt;
    logic [GAIN_W-1:0] delta;
    logic [GAIN_W-1:0] gain_new;

    always_comb
    begin
        lim_prod = gain_reg[GAIN_W-1:2] * RECIP5;
        tgt      = '0;
        delta    = '0;
        if (max_reg == '0)
        begin
            tgt      = GAIN_MAX;
            delta    = tgt - gain_reg;
            if (delta > {4'd0, lim_reg})
            begin
                delta = {4'd0, lim_reg};
            end
            gain_new = gain_reg + delta;
        end
        else if (num_reg < {{(NUM_W-GAIN_W){1'b0}}, gain_reg})
        begin
            gain_new = num_reg[GAIN_W-1:0];
        end
        else
        begin
            tgt = (num_reg > {{(NUM_W-GAIN_W){1'b0}}, GAIN_MAX}) ? GAIN_MAX
                                                                : num_reg[GAIN_W-1:0];
            delta = tgt - gain_reg;
            if (delta > {4'd0, lim_reg})
            begin
                delta = {4'd0, lim_reg};
            end
            gain_new = gain_reg + delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_en_reg      <= 1'b1;
            pos_reg         <= '0;
            bank_reg        <= 1'b0;
            end_reg         <= 1'b0;
            peak_reg        <= '0;
            slot_reg        <= '0;
            scan_reg        <= '0;
            div_cnt_reg     <= '0;
            gain_reg        <= GAIN_RESET;
            drain_gain_reg  <= '0;
            drain_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                agc_en_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                end_reg <= (pos_reg == POS_LAST);
                pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                if (in_peak > peak_reg)
                begin
                    peak_reg <= in_peak;
                end
            end
            if (cmd.emit && drain_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.hist_write)
            begin
                hist_reg[slot_reg] <= peak_reg;
                slot_reg           <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                scan_reg           <= '0;
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                gain_reg <= gain_new;
            end
            if (cmd.swap)
            begin
                bank_reg        <= ~bank_reg;
                drain_gain_reg  <= gain_reg;
                drain_valid_reg <= 1'b1;
                peak_reg        <= '0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_reg <= rd_mag * drain_gain_reg;
            neg_reg  <= rd_sample[SAMPLE_W-1];
        end
        if (cmd.emit && drain_valid_reg)
        begin
            sample_out_reg <= rnd_out;
            gain_out_reg   <= drain_gain_reg;
            frame_end_reg  <= end_reg;
        end
        if (cmd.hist_write)
        begin
            max_reg <= '0;
        end
        if (cmd.scan_step && (hist_reg[scan_reg] > max_reg))
        begin
            max_reg <= hist_reg[scan_reg];
        end
        if (cmd.div_init)
        begin
            num_reg <= TARGET_NUM;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[PEAK_W-1:0] : div_sh[PEAK_W-1:0];
        end
        if (cmd.limit)
        begin
            lim_reg <= lim_prod[39:22];
        end
    end

    assign status.end_of_frame = end_reg;
    assign status.drain_valid  = drain_valid_reg;
    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.agc_en       = agc_en_reg;
    assign status.scan_last    = (scan_reg == SLOT_LAST);
    assign status.div_last     = (div_cnt_reg == DIV_LAST);

    assign out_valid    = out_valid_reg;
    assign sample_out   = sample_out_reg;
    assign applied_gain = gain_out_reg;
    assign frame_end    = frame_end_reg;

    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_MAX)
        else $error("current gain above 50.0");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position out of range");

    a_out_needs_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> drain_valid_reg)
        else $error("result shown before a frame was drained");

    a_swap_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap |-> (pos_reg == '0))
        else $error("frame swap with a partly filled frame");

endmodule

>>> hdl/peak_history_audio_agc.sv
// Top level of the peak-hold automatic gain control for speech audio.
// Depends on phagc_pkg, phagc_ctrl and phagc_dp (which holds phagc_ram).
//
// Usage: samples enter on the in_valid / in_ready channel, one beat per
// sample, in frames of FRAME_LEN. Each beat on the input releases one beat on
// the out_valid / out_ready channel carrying the matching sample of the
// previous frame, multiplied by that frame's gain, rounded half to even and
// saturated to +-32767, with the gain and a frame_end flag. The first frame
// after reset produces no output beats.
// An ordinary sample passes acceptance (buffer write and read), product,
// then rounding into the output register, a step that waits while the
// receiver has not taken the previous result. At the last sample of a frame,
// with adaptation enabled, the controller then scans the peak history, runs
// a one-bit-per-cycle divider, limits the rise and updates the gain before
// the buffers swap; with adaptation disabled it only swaps the buffers.
// The output register decouples the sides: a new sample is accepted while a
// result still waits. Input is held off while a sample is being worked on,
// and longer when a second result would overwrite one not yet taken.
// Reset clears the peak history, the frame position and the output valid
// flag, sets the gain to 25.0 and enables adaptation. The adaptation enable
// is written through cfg_wr_en / cfg_wr_data and is only to be changed while
// the block is idle.
module peak_history_audio_agc
    import phagc_pkg::*;
#(
    parameter int FRAME_LEN     = 160,
    parameter int HISTORY_DEPTH = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_W-1:0]    sample_out,
    output logic [GAIN_W-1:0]          applied_gain,
    output logic                       frame_end,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data
);

    phagc_cmd_t    cmd;
    phagc_status_t status;

    phagc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    phagc_dp #(
        .FRAME_LEN     (FRAME_LEN),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_in    (sample_in),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .sample_out   (sample_out),
        .applied_gain (applied_gain),
        .frame_end    (frame_end)
    );

endmodule

>>> test/testbench.sv
// Regression testbench for the peak-hold audio AGC top level.
// Depends on phagc_pkg and peak_history_audio_agc; the model of the gain law
// and the frame buffers is kept here, written against the package widths.
`timescale 1ns / 100ps

module testbench;
    import phagc_pkg::*;

    localparam int FRAME_LEN     = 160;
    localparam int HISTORY_DEPTH = 25;
    localparam int RANDOM_ITEMS  = 150;
    localparam int CYCLE_LIMIT   = 2000000;
    // Worst frame end: history scan plus divider and a margin.
    localparam int SETTLE_CYCLES = HISTORY_DEPTH + 80;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic [GAIN_W-1:0]       gain;
        logic                    last;
    } gained_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] sample_out;
    logic [GAIN_W-1:0] applied_gain;
    logic frame_end;
    logic cfg_wr_en;
    logic cfg_wr_data;

    // Model state, mirroring the block after reset.
    logic                 agc_on;
    logic signed [23:0]   fill_buf [FRAME_LEN];
    logic signed [23:0]   drain_buf [FRAME_LEN];
    int unsigned          fill_pos;
    logic [PEAK_W-1:0]    peak_now;
    logic [PEAK_W-1:0]    peak_ring [HISTORY_DEPTH];
    int unsigned          ring_slot;
    logic [GAIN_W-1:0]    gain_now;
    logic [GAIN_W-1:0]    gain_drain;
    logic                 drain_full;

    gained_beat_t expected_beats [$];
    int  error_count;
    int  beats_checked;
    int  samples_sent;
    longint cycle_count = 0;

    peak_history_audio_agc #(
        .FRAME_LEN     (FRAME_LEN),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .applied_gain (applied_gain),
        .frame_end    (frame_end),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The cycle counter guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("peak_history_audio_agc regression: fail");
            $finish;
        end
    end

    // Multiply a sample by a Q6.16 gain, round the magnitude half to even and
    // saturate it before the sign is put back.
    function automatic logic signed [OUT_W-1:0] gained_sample(
        input logic signed [23:0] s, input logic [GAIN_W-1:0] g);
        logic [24:0] mag;
        logic [47:0] prod;
        logic [23:0] q;
        logic [23:0] frac;
        begin
            mag  = s[23] ? -{s[23], s} : {1'b0, s};
            prod = 48'(mag) * 48'(g);
            q    = prod[47:24];
            frac = prod[23:0];
            if (frac > 24'h800000 || (frac == 24'h800000 && q[0]))
                q = q + 24'd1;
            if (q > 24'd32767)
                q = 24'd32767;
            gained_sample = s[23] ? -OUT_W'(q) : OUT_W'(q);
        end
    endfunction

    // With adaptation on, a frame's close takes a gain fall at once; a rise is
    // clamped to 50.0 and limited to a twentieth of the present gain.
    task automatic close_frame();
        logic [PEAK_W-1:0] loudest;
        logic [63:0] target;
        logic [63:0] step;
        logic [63:0] step_limit;
        begin
            if (agc_on)
            begin
                peak_ring[ring_slot] = peak_now;
                ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
                loudest = '0;
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    if (peak_ring[i] > loudest)
                        loudest = peak_ring[i];
                target = (loudest != 0) ? 64'd503316480000 / loudest : 64'(GAIN_MAX);
                if (target < gain_now)
                    gain_now = GAIN_W'(target);
                else
                begin
                    if (target > GAIN_MAX)
                        target = 64'(GAIN_MAX);
                    step = target - gain_now;
                    step_limit = gain_now / 20;
                    if (step > step_limit)
                        step = step_limit;
                    gain_now = GAIN_W'(gain_now + step);
                end
            end
            drain_buf  = fill_buf;
            gain_drain = gain_now;
            drain_full = 1'b1;
            peak_now   = '0;
            fill_pos   = 0;
        end
    endtask

    // Advance the model by one accepted sample and queue the beat it releases.
    task automatic predict_gained_beat(input logic signed [23:0] s);
        gained_beat_t beat;
        logic [23:0] mag;
        begin
            if (drain_full)
            begin
                beat.sample = gained_sample(drain_buf[fill_pos], gain_drain);
                beat.gain   = gain_drain;
                beat.last   = (fill_pos == FRAME_LEN - 1);
                expected_beats.push_back(beat);
            end
            fill_buf[fill_pos] = s;
            mag = s[23] ? -s : s;
            // The most negative sample wraps to itself; hold it at the peak limit.
            if (mag > 24'(PEAK_MAX))
                mag = 24'(PEAK_MAX);
            if (PEAK_W'(mag) > peak_now)
                peak_now = PEAK_W'(mag);
            if (fill_pos == FRAME_LEN - 1)
                close_frame();
            else
                fill_pos++;
        end
    endtask

    // Send one sample after a random gap, updating the model on acceptance.
    // Valid is left high after acceptance; the next gap, the next sample or a
    // drain takes it down, so that it is driven once per time step.
    task automatic send_sample(input logic signed [23:0] s);
        int gap;
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            sample_in <= s;
            do
                @(posedge clk);
            while (!in_ready);
            predict_gained_beat(s);
            samples_sent++;
        end
    endtask

    // The receiver stalls by a random number of cycles before each beat; every
    // accepted beat is compared against the oldest expectation.
    initial
    begin : receiver
        int stall;
        gained_beat_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 5);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: sample_out %0d", sample_out);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (sample_out !== want.sample)
                begin
                    $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
                    error_count++;
                end
                if (applied_gain !== want.gain)
                begin
                    $error("applied_gain: expected %0d, got %0d", want.gain, applied_gain);
                    error_count++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end: expected %0b, got %0b", want.last, frame_end);
                    error_count++;
                end
            end
        end
    end

    // Wait until the receiver has drained every expectation, then let the
    // block finish any frame-end work that yields no beat.
    task automatic wait_until_drained();
        begin
            in_valid <= 1'b0;
            while (expected_beats.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_adapt_mode(input logic value);
        begin
            wait_until_drained();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            agc_on = value;
        end
    endtask

    // Random speech-like sample: mostly moderate levels so that the gain both
    // rises and falls, now and then a full-scale or silent stretch.
    function automatic logic signed [23:0] random_sample(input int level);
        logic [23:0] raw;
        begin
            raw = 24'($urandom);
            case (level)
                0: random_sample = 24'sd0;
                1: random_sample = $signed(raw) >>> 12;
                2: random_sample = $signed(raw) >>> 6;
                default: random_sample = raw;
            endcase
        end
    endfunction

    // Directed extremes: full scale of both signs, the most negative code,
    // zero and small values; the first frame yields no beats.
    task automatic test_extremes();
        logic signed [23:0] corner [8];
        begin
            corner = '{24'sh7FFFFF, -24'sh7FFFFF, 24'sh800000, 24'sd0,
                       24'sd1, -24'sd1, 24'sd128, -24'sd384};
            for (int i = 0; i < 24; i++)
                send_sample(corner[i % 8]);
            while (fill_pos != 0)
                send_sample(random_sample(1));
        end
    endtask

    // Two silent frames, then a loud one; the history still holds the full-scale
    // peak of the extremes test, so the gain is held at its level.
    task automatic test_gain_law();
        begin
            for (int f = 0; f < 3; f++)
                for (int i = 0; i < FRAME_LEN; i++)
                    send_sample(f == 2 ? random_sample(3) : random_sample(0));
        end
    endtask

    // With adaptation off the gain is held and the history is left alone.
    task automatic test_gain_hold();
        begin
            write_adapt_mode(1'b0);
            for (int i = 0; i < FRAME_LEN; i++)
                send_sample(random_sample($urandom_range(1, 3)));
            write_adapt_mode(1'b1);
        end
    endtask

    // Random samples, level drawn at frame start; one pause for a full drain.
    task automatic test_random_frames();
        int level;
        begin
            level = 2;
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                if (fill_pos == 0)
                    level = $urandom_range(0, 3);
                if (i == RANDOM_ITEMS / 2)
                    wait_until_drained();
                send_sample(random_sample(level));
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample_in   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        error_count = 0;
        beats_checked = 0;
        samples_sent  = 0;
        agc_on     = 1'b1;
        fill_pos   = 0;
        peak_now   = '0;
        ring_slot  = 0;
        gain_now   = GAIN_RESET;
        gain_drain = '0;
        drain_full = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            peak_ring[i] = '0;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            fill_buf[i]  = '0;
            drain_buf[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_gain_law();
        test_gain_hold();
        write_adapt_mode(1'b1);
        test_random_frames();
        wait_until_drained();

        $display("Sent %0d samples and checked %0d gained beats,", samples_sent,
                 beats_checked);
        $display("with adaptation both on and off and a full drain mid-run.");
        if (error_count == 0)
            $display("peak_history_audio_agc regression: pass");
        else
            $display("peak_history_audio_agc regression: fail");
        $finish;
    end

endmodule
